>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top of the grid line walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/glpw_pkg.sv
// Types and constants of the grid line walker.
package glpw_pkg;

    localparam int COORD_W = 5;
    localparam int MAG_W   = COORD_W + 1;
    localparam int PROD_W  = 12;
    localparam int CNT_W   = 6;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_WALK  = 3'b100
    } t_state;

endpackage

>>> hw/rtl/grid_line_path_walker_top.sv
// Grid line walker: emits every grid cell crossed by a line from start to end.
// A request is registered, set up in ST_SETUP, then walked out through the output register.
// Throughput: one cell per cycle while i_ready is high, from one shared compare/accumulate
// step; a new request is taken only once the walk has ended, cells <= |dx| + |dy| + 1.
// Synchronous active-low reset returns the sequencer to idle with no output pending.
`include "assert_macros.svh"

module grid_line_path_walker_top #(
    parameter int GRID_SIZE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  glpw_pkg::t_coord  i_start_x,
    input  glpw_pkg::t_coord  i_start_y,
    input  glpw_pkg::t_coord  i_end_x,
    input  glpw_pkg::t_coord  i_end_y,
    output logic              o_valid,
    input  logic              i_ready,
    output glpw_pkg::t_coord  o_cell_x,
    output glpw_pkg::t_coord  o_cell_y,
    output logic              o_last
);
    import glpw_pkg::*;

    localparam int     MaxCells = 2 * (GRID_SIZE - 1) + 1;
    localparam t_coord CoordMax = COORD_W'(GRID_SIZE - 1);
    localparam t_cnt   CntLast  = CNT_W'(MaxCells - 1);

    function automatic t_coord clamp(input t_coord v);
        return (v > CoordMax) ? CoordMax : v;
    endfunction

    t_state r_state, n_state;
    t_coord r_px, n_px, r_py, n_py;
    t_coord r_ex, n_ex, r_ey, n_ey;
    t_coord r_lim, n_lim;
    t_mag   r_mx, n_mx, r_my, n_my;
    t_mag   r_ia, n_ia, r_ib, n_ib;
    t_prod  r_pa, n_pa, r_pb, n_pb;
    t_cnt   r_cnt, n_cnt;
    logic   r_negx, n_negx, r_negy, n_negy;
    logic   r_movx, n_movx, r_movy, n_movy;
    logic   r_zero, n_zero;
    logic   r_ovalid, n_ovalid;
    t_coord r_ocx, r_ocy;
    logic   r_olast;

    t_coord w_adx, w_ady;
    logic   w_lt, w_eq, w_mvx, w_mvy, w_fin, w_load;
    t_mag   w_nmx, w_nmy;

    always_comb begin
        w_adx = (r_ex >= r_px) ? r_ex - r_px : r_px - r_ex;
        w_ady = (r_ey >= r_py) ? r_ey - r_py : r_py - r_ey;
        // Products A = |dy|*(2|ox|+1) and B = |dx|*(2|oy|+1) are kept as
        // running sums, so each step needs only a compare and one add per moving sum.
        w_lt  = r_pa < r_pb;
        w_eq  = r_pa == r_pb;
        w_mvx = (w_lt || w_eq) && r_movx;
        w_mvy = !w_lt && r_movy;
        w_nmx = r_mx + t_mag'(w_mvx);
        w_nmy = r_my + t_mag'(w_mvy);
        w_fin = r_zero || (w_nmx > {1'b0, r_lim}) || (w_nmy > {1'b0, r_lim})
                || (r_cnt >= CntLast);
        w_load = 1'b0;

        n_state = r_state;
        n_px = r_px;  n_py = r_py;
        n_ex = r_ex;  n_ey = r_ey;
        n_lim = r_lim;
        n_mx = r_mx;  n_my = r_my;
        n_ia = r_ia;  n_ib = r_ib;
        n_pa = r_pa;  n_pb = r_pb;
        n_cnt = r_cnt;
        n_negx = r_negx;  n_negy = r_negy;
        n_movx = r_movx;  n_movy = r_movy;
        n_zero = r_zero;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_px = clamp(i_start_x);
                    n_py = clamp(i_start_y);
                    n_ex = clamp(i_end_x);
                    n_ey = clamp(i_end_y);
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_negx = r_ex < r_px;
                n_negy = r_ey < r_py;
                n_movx = r_ex != r_px;
                n_movy = r_ey != r_py;
                n_zero = (r_ex == r_px) && (r_ey == r_py);
                n_lim  = (w_adx > w_ady) ? w_adx : w_ady;
                n_ia   = {w_ady, 1'b0};
                n_ib   = {w_adx, 1'b0};
                n_pa   = PROD_W'(w_ady);
                n_pb   = PROD_W'(w_adx);
                n_mx   = '0;
                n_my   = '0;
                n_cnt  = '0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!r_ovalid || i_ready) begin
                    w_load = 1'b1;
                    n_mx = w_nmx;
                    n_my = w_nmy;
                    n_cnt = r_cnt + t_cnt'(1);
                    if (w_mvx) begin
                        n_pa = r_pa + PROD_W'(r_ia);
                        n_px = r_negx ? r_px - t_coord'(1) : r_px + t_coord'(1);
                    end
                    if (w_mvy) begin
                        n_pb = r_pb + PROD_W'(r_ib);
                        n_py = r_negy ? r_py - t_coord'(1) : r_py + t_coord'(1);
                    end
                    if (w_fin) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;  r_py <= n_py;
        r_ex <= n_ex;  r_ey <= n_ey;
        r_lim <= n_lim;
        r_mx <= n_mx;  r_my <= n_my;
        r_ia <= n_ia;  r_ib <= n_ib;
        r_pa <= n_pa;  r_pb <= n_pb;
        r_cnt <= n_cnt;
        r_negx <= n_negx;  r_negy <= n_negy;
        r_movx <= n_movx;  r_movy <= n_movy;
        r_zero <= n_zero;
        if (w_load) begin
            r_ocx   <= r_px;
            r_ocy   <= r_py;
            r_olast <= w_fin;
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_cell_x = r_ocx;
    assign o_cell_y = r_ocy;
    assign o_last   = r_olast;

    `ASSERT_PROP(a_offset_in_limit, i_clk, i_rst_n, (r_state == ST_WALK) |-> (r_mx <= {1'b0, r_lim} && r_my <= {1'b0, r_lim}), "offset passed the limit while walking")
    `ASSERT_PROP(a_accept_to_setup, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state == ST_SETUP), "accepted request did not start setup")
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, (r_state == ST_WALK) && (r_cnt > CntLast), "cell count passed the path bound")
    `ASSERT_NEVER(a_zero_single, i_clk, i_rst_n, (r_state == ST_WALK) && r_zero && (r_cnt != '0), "same-cell request emitted more than one word")

endmodule

>>> tb/grid_line_path_walker_top_tb.sv
// Self-checking testbench for the grid line walker: line requests in, path cells out.
`timescale 1ns / 1ps

module grid_line_path_walker_top_tb;
    import glpw_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int GRID_SIZE      = 32;
    localparam int GRID_LAST      = GRID_SIZE - 1;
    localparam int MAX_PATH_CELLS = 2 * (GRID_SIZE - 1) + 1;
    localparam int RANDOM_LINES   = 390;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 16;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_cell_word;

    // Walks each accepted line in software and checks the cells that come back in order.
    class path_cell_scoreboard;
        t_cell_word expected_cells[$];
        int lines_noted;
        int cells_checked;
        int bad_cells;
        int longest_path;
        int single_cell_lines;

        function new();
            lines_noted       = 0;
            cells_checked     = 0;
            bad_cells         = 0;
            longest_path      = 0;
            single_cell_lines = 0;
        endfunction

        function int mag_of(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int sign_of(int v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function int chess_dist(int a, int b);
            return (mag_of(a) > mag_of(b)) ? mag_of(a) : mag_of(b);
        endfunction

        function void note_request(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
            int org_x;
            int org_y;
            int dst_x;
            int dst_y;
            int dx;
            int dy;
            int ox;
            int oy;
            int reach;
            int prod_a;
            int prod_b;
            int cells;
            bit done;
            t_cell_word w;
            org_x = sx;
            org_y = sy;
            dst_x = ex;
            dst_y = ey;
            if (org_x > GRID_LAST) org_x = GRID_LAST;
            if (org_y > GRID_LAST) org_y = GRID_LAST;
            if (dst_x > GRID_LAST) dst_x = GRID_LAST;
            if (dst_y > GRID_LAST) dst_y = GRID_LAST;
            dx    = dst_x - org_x;
            dy    = dst_y - org_y;
            ox    = 0;
            oy    = 0;
            reach = chess_dist(dx, dy);
            cells = 0;
            done  = 1'b0;
            while (!done) begin
                w.x = t_coord'(org_x + ox);
                w.y = t_coord'(org_y + oy);
                // A zero-length line forces the offset past the end so that one cell comes out.
                if (dx == 0 && dy == 0) begin
                    ox = 1;
                    oy = 0;
                end
                prod_a = mag_of(dy) * (2 * mag_of(ox) + 1);
                prod_b = mag_of(dx) * (2 * mag_of(oy) + 1);
                if (prod_a < prod_b) begin
                    ox += sign_of(dx);
                end else if (prod_a == prod_b) begin
                    ox += sign_of(dx);
                    oy += sign_of(dy);
                end else begin
                    oy += sign_of(dy);
                end
                done   = (chess_dist(ox, oy) > reach) || (cells + 1 >= MAX_PATH_CELLS);
                w.last = done;
                expected_cells.push_back(w);
                cells++;
            end
            lines_noted++;
            if (cells > longest_path) longest_path = cells;
            if (cells == 1) single_cell_lines++;
        endfunction

        function void check_cell(t_coord x, t_coord y, logic last);
            t_cell_word w;
            cells_checked++;
            if (expected_cells.size() == 0) begin
                bad_cells++;
                if (bad_cells <= 10)
                    $display("%0t: unexpected cell x=%0d y=%0d last=%0b",
                             $realtime, x, y, last);
                return;
            end
            w = expected_cells.pop_front();
            if (w.x !== x || w.y !== y || w.last !== last) begin
                bad_cells++;
                if (bad_cells <= 10) begin
                    $display("%0t: cell mismatch: expected x=%0d y=%0d last=%0b",
                             $realtime, w.x, w.y, w.last);
                    $display("%0t:                got      x=%0d y=%0d last=%0b",
                             $realtime, x, y, last);
                end
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   i_valid   = 1'b0;
    logic   i_ready   = 1'b0;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_end_x   = '0;
    t_coord i_end_y   = '0;
    logic   o_ready;
    logic   o_valid;
    t_coord o_cell_x;
    t_coord o_cell_y;
    logic   o_last;

    path_cell_scoreboard sb;
    bit no_idle        = 1'b0;
    bit long_hold_done = 1'b0;
    int rx_hold        = 0;
    int stall_cycles   = 0;
    int directed_lines = 0;

    grid_line_path_walker_top #(.GRID_SIZE(GRID_SIZE)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cell_x  (o_cell_x),
        .o_cell_y  (o_cell_y),
        .o_last    (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(sx, sy, ex, ey);
    endtask

    task automatic send_random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int kind;
        int span;
        sx   = $urandom_range(0, GRID_LAST);
        sy   = $urandom_range(0, GRID_LAST);
        ex   = $urandom_range(0, GRID_LAST);
        ey   = $urandom_range(0, GRID_LAST);
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // fully random endpoints
        end else if (kind < 70) begin
            // short lines keep the run fast and hit the small-delta ratios
            ex = sx + $urandom_range(0, 8) - 4;
            ey = sy + $urandom_range(0, 8) - 4;
        end else if (kind < 80) begin
            if ($urandom_range(0, 1)) ex = sx;
            else ey = sy;
        end else if (kind < 88) begin
            if ($urandom_range(0, 1)) sx = $urandom_range(0, 1) * GRID_LAST;
            if ($urandom_range(0, 1)) sy = $urandom_range(0, 1) * GRID_LAST;
            if ($urandom_range(0, 1)) ex = $urandom_range(0, 1) * GRID_LAST;
            if ($urandom_range(0, 1)) ey = $urandom_range(0, 1) * GRID_LAST;
        end else if (kind < 93) begin
            ex = sx;
            ey = sy;
        end else begin
            span = $urandom_range(1, GRID_LAST);
            ex   = $urandom_range(0, 1) ? sx + span : sx - span;
            ey   = $urandom_range(0, 1) ? sy + span : sy - span;
        end
        if (ex < 0) ex = 0;
        if (ex > GRID_LAST) ex = GRID_LAST;
        if (ey < 0) ey = 0;
        if (ey > GRID_LAST) ey = GRID_LAST;
        send_request(t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey));
    endtask

    // Receiver: checks every accepted word and stalls at random, once for a long stretch.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_cell(o_cell_x, o_cell_y, o_last);
            if (rx_hold == 0 && !no_idle && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
            if (!long_hold_done && sb.cells_checked >= 300) begin
                rx_hold        = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d cells still expected",
                         $realtime, stall_cycles, sb.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: corners, full-length axes and diagonals, unit steps, steep and shallow.
        send_request(5'd0,  5'd0,  5'd0,  5'd0);
        send_request(5'd31, 5'd31, 5'd31, 5'd31);
        send_request(5'd0,  5'd0,  5'd31, 5'd31);
        send_request(5'd31, 5'd31, 5'd0,  5'd0);
        send_request(5'd0,  5'd31, 5'd31, 5'd0);
        send_request(5'd31, 5'd0,  5'd0,  5'd31);
        send_request(5'd0,  5'd0,  5'd31, 5'd0);
        send_request(5'd0,  5'd0,  5'd0,  5'd31);
        send_request(5'd31, 5'd0,  5'd0,  5'd0);
        send_request(5'd0,  5'd31, 5'd0,  5'd0);
        send_request(5'd5,  5'd5,  5'd6,  5'd5);
        send_request(5'd5,  5'd5,  5'd5,  5'd4);
        send_request(5'd0,  5'd0,  5'd31, 5'd1);
        send_request(5'd0,  5'd0,  5'd1,  5'd31);
        send_request(5'd10, 5'd10, 5'd13, 5'd12);
        send_request(5'd31, 5'd31, 5'd0,  5'd30);
        send_request(5'd7,  5'd20, 5'd20, 5'd7);
        send_request(5'd0,  5'd0,  5'd31, 5'd30);
        send_request(5'd16, 5'd16, 5'd15, 5'd17);
        send_request(5'd21, 5'd10, 5'd10, 5'd21);
        directed_lines = sb.lines_noted;

        for (int n = 0; n < RANDOM_LINES; n++) begin
            no_idle = (n >= 150 && n < 200);
            send_random_line();
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d line requests (%0d directed, %0d single-cell), %0d cells checked.",
                 sb.lines_noted, directed_lines, sb.single_cell_lines, sb.cells_checked);
        $display("Longest path %0d cells; long output stall exercised: %0b; mismatches: %0d.",
                 sb.longest_path, long_hold_done, sb.bad_cells);
        if (sb.bad_cells == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/glpw_pkg.sv
hw/rtl/grid_line_path_walker_top.sv
tb/grid_line_path_walker_top_tb.sv
